// ===== src/chained_range_remap_min_assert.svh =====
// Assertion macros for the chained range remap block.
// Used by the port-level checker; no other dependencies.
`ifndef CHAINED_RANGE_REMAP_MIN_ASSERT_SVH
`define CHAINED_RANGE_REMAP_MIN_ASSERT_SVH

// Check that a condition implies a consequence in the next cycle.
`define CRR_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define CRR_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/crr_pkg.sv =====
// Package for the chained range remap block: field widths, codes, controller states,
// command and status structs. No dependencies.
`default_nettype none
package crr_pkg;
	localparam int unsigned OP_W = 1;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;
	localparam int unsigned CFG_W = 4;
	localparam logic [CFG_W-1:0] STAGES_RESET = 4'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_LAST,
		ST_APPLY,
		ST_OUT
	} crr_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;   // capture request fields
		logic write_ent;  // write table entry
		logic clear_ent;  // clear whole entry at clear address
		logic scan_rd;    // read entry at scan address
		logic scan_cmp;   // compare last read entry
		logic stage_init; // reset best tracking
		logic apply;      // apply best to value
		logic out_load;   // load result register
	} crr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_translate;
		logic write_ok;
	} crr_stat_t;
endpackage
`default_nettype wire

// ===== src/crr_if.sv =====
// Valid/ready stream interfaces for the chained range remap block.
// Depends on nothing.
`default_nettype none
interface crr_req_if #(parameter int unsigned VALUE_WIDTH = 48);
	logic valid;
	logic ready;
	logic operation;
	logic [2:0] stage_index;
	logic [5:0] slot_index;
	logic [VALUE_WIDTH-1:0] entry_destination;
	logic [VALUE_WIDTH-1:0] entry_source;
	logic [VALUE_WIDTH-1:0] entry_length;
	logic entry_enable;
	logic [VALUE_WIDTH-1:0] in_value;
	logic batch_last;
	modport source (output valid, operation, stage_index, slot_index, entry_destination,
		entry_source, entry_length, entry_enable, in_value, batch_last, input ready);
	modport sink (input valid, operation, stage_index, slot_index, entry_destination,
		entry_source, entry_length, entry_enable, in_value, batch_last, output ready);
endinterface

interface crr_rsp_if #(parameter int unsigned VALUE_WIDTH = 48);
	logic valid;
	logic ready;
	logic [VALUE_WIDTH-1:0] location_value;
	logic [VALUE_WIDTH-1:0] batch_minimum;
	logic batch_done;
	modport source (output valid, location_value, batch_minimum, batch_done, input ready);
	modport sink (input valid, location_value, batch_minimum, batch_done, output ready);
endinterface
`default_nettype wire

// ===== src/chained_range_remap_min.sv =====
// Chained range remap with running batch minimum.
// Requests arrive on req (valid/ready); a write request loads or clears one table entry
// and yields no result; a translate request yields one result on rsp.
// A translate walks stages_in_use stages (capped at STAGE_COUNT); each stage reads all
// ENTRIES_PER_STAGE entries of the table memory one per cycle, then applies the best.
// A write returns to waiting once its table write is done; a translate loads its result
// into the output register once its last stage is applied, and the next request is
// accepted only after that. The single table read port sets the pace of the scans.
// One request is in flight at a time; req.ready is high only while the block waits.
// After reset the block sweeps the table memory, clearing every entry, with req.ready
// low; stages_in_use resets to 7.
// The result sits in an output register; if rsp is stalled a following translate runs
// its scan and then holds, with req.ready low, until the register frees.
// The user writes stages_in_use (cfg_we/cfg_data) only while no request is in flight;
// the block does not enforce this. Depends on crr_pkg, crr_if, crr_ctrl, crr_datapath.
`default_nettype none
module chained_range_remap_min
	import crr_pkg::*;
#(
	parameter int unsigned STAGE_COUNT = 8,
	parameter int unsigned ENTRIES_PER_STAGE = 64,
	parameter int unsigned VALUE_WIDTH = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_W-1:0] cfg_data,
	crr_req_if.sink req,
	crr_rsp_if.source rsp
);
	localparam int unsigned STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
	localparam int unsigned SLT_W = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
	localparam int unsigned ADR_W = STG_W + SLT_W;

	logic [CFG_W-1:0] stages_q;
	crr_cmd_t cmd;
	crr_stat_t stat;
	logic [ADR_W-1:0] scan_addr, clear_addr;
	logic rd_valid_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stages_q <= STAGES_RESET;
		else if (cfg_we)
			stages_q <= cfg_data;
	end

	crr_ctrl #(.STAGE_COUNT(STAGE_COUNT), .ENTRIES_PER_STAGE(ENTRIES_PER_STAGE)) u_ctrl (
		.clk, .arst_n, .stages_in_use(stages_q),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd, .stat, .scan_addr, .clear_addr, .rd_valid_in
	);

	crr_datapath #(.STAGE_COUNT(STAGE_COUNT), .ENTRIES_PER_STAGE(ENTRIES_PER_STAGE),
		.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .scan_addr, .clear_addr, .rd_valid_in,
		.req_operation(req.operation), .req_stage(req.stage_index),
		.req_slot(req.slot_index), .req_dest(req.entry_destination),
		.req_src(req.entry_source), .req_len(req.entry_length),
		.req_enable(req.entry_enable), .req_value(req.in_value),
		.req_last(req.batch_last),
		.location_value(rsp.location_value), .batch_minimum(rsp.batch_minimum),
		.batch_done(rsp.batch_done)
	);
endmodule
`default_nettype wire

// ===== src/crr_datapath.sv =====
// Datapath: range table memory, best-entry scan, value chain, batch minimum, result.
// Depends on crr_pkg.
`default_nettype none
module crr_datapath
	import crr_pkg::*;
#(
	parameter int unsigned STAGE_COUNT = 8,
	parameter int unsigned ENTRIES_PER_STAGE = 64,
	parameter int unsigned VALUE_WIDTH = 48,
	parameter int unsigned STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1,
	parameter int unsigned SLT_W = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1,
	parameter int unsigned ADR_W = STG_W + SLT_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire crr_cmd_t cmd,
	output crr_stat_t stat,
	input wire logic [ADR_W-1:0] scan_addr,
	input wire logic [ADR_W-1:0] clear_addr,
	input wire logic rd_valid_in,
	input wire logic req_operation,
	input wire logic [2:0] req_stage,
	input wire logic [5:0] req_slot,
	input wire logic [VALUE_WIDTH-1:0] req_dest,
	input wire logic [VALUE_WIDTH-1:0] req_src,
	input wire logic [VALUE_WIDTH-1:0] req_len,
	input wire logic req_enable,
	input wire logic [VALUE_WIDTH-1:0] req_value,
	input wire logic req_last,
	output logic [VALUE_WIDTH-1:0] location_value,
	output logic [VALUE_WIDTH-1:0] batch_minimum,
	output logic batch_done
);
	localparam int unsigned DEPTH = STAGE_COUNT * ENTRIES_PER_STAGE;
	// entry word: valid, destination, source, length
	localparam int unsigned ENT_W = 3 * VALUE_WIDTH + 1;

	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic rd_vld_q;

	logic op_q, last_q, en_q;
	logic [2:0] stg_q;
	logic [5:0] slt_q;
	logic [VALUE_WIDTH-1:0] dst_q, src_q, len_q, val_q;

	logic found_q;
	logic [VALUE_WIDTH-1:0] bdst_q, bsrc_q, blen_q;
	logic [VALUE_WIDTH-1:0] min_q;
	logic empty_q;

	logic r_vld;
	logic [VALUE_WIDTH-1:0] r_dst, r_src, r_len, offset, new_min;

	assign stat.is_translate = (op_q == OP_TRANSLATE);
	assign stat.write_ok = (32'(stg_q) < STAGE_COUNT) && (32'(slt_q) < ENTRIES_PER_STAGE);

	logic [ADR_W-1:0] waddr_c;
	always_comb begin
		waddr_c = ADR_W'(32'(stg_q) * ENTRIES_PER_STAGE + 32'(slt_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q <= req_operation;
			stg_q <= req_stage;
			slt_q <= req_slot;
			dst_q <= req_dest;
			src_q <= req_src;
			len_q <= req_len;
			en_q <= req_enable;
			last_q <= req_last;
		end
		if (cmd.clear_ent)
			mem[clear_addr] <= '0;
		else if (cmd.write_ent)
			mem[waddr_c] <= {en_q, dst_q, src_q, len_q};
		if (cmd.scan_rd)
			rd_q <= mem[scan_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.scan_rd)
				rd_vld_q <= rd_valid_in;
		end
	end

	assign r_vld = rd_vld_q & rd_q[ENT_W-1];
	assign r_dst = rd_q[ENT_W-2 -: VALUE_WIDTH];
	assign r_src = rd_q[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
	assign r_len = rd_q[VALUE_WIDTH-1:0];
	assign offset = val_q - bsrc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.stage_init) begin
			found_q <= 1'b0;
		end else if (cmd.scan_cmp && r_vld && r_src <= val_q
				&& (!found_q || r_src > bsrc_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req)
			val_q <= req_value;
		else if (cmd.apply && found_q && offset < blen_q)
			val_q <= bdst_q + offset;
		if (cmd.scan_cmp && r_vld && r_src <= val_q && (!found_q || r_src > bsrc_q)) begin
			bdst_q <= r_dst;
			bsrc_q <= r_src;
			blen_q <= r_len;
		end
	end

	assign new_min = (empty_q || val_q < min_q) ? val_q : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			empty_q <= 1'b1;
		end else if (cmd.out_load) begin
			min_q <= last_q ? '1 : new_min;
			empty_q <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			location_value <= val_q;
			batch_minimum <= new_min;
			batch_done <= last_q;
		end
	end
endmodule
`default_nettype wire

// ===== src/crr_ctrl.sv =====
// Controller: sequences write, valid clear and per-stage scans; owns the handshake.
// Depends on crr_pkg.
`default_nettype none
module crr_ctrl
	import crr_pkg::*;
#(
	parameter int unsigned STAGE_COUNT = 8,
	parameter int unsigned ENTRIES_PER_STAGE = 64,
	parameter int unsigned STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1,
	parameter int unsigned SLT_W = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1,
	parameter int unsigned ADR_W = STG_W + SLT_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [CFG_W-1:0] stages_in_use,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output crr_cmd_t cmd,
	input wire crr_stat_t stat,
	output logic [ADR_W-1:0] scan_addr,
	output logic [ADR_W-1:0] clear_addr,
	output logic rd_valid_in
);
	localparam int unsigned DEPTH = STAGE_COUNT * ENTRIES_PER_STAGE;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SC_W = $clog2(ENTRIES_PER_STAGE + 1);
	localparam int unsigned ST_W = $clog2(STAGE_COUNT + 1) > CFG_W ?
		$clog2(STAGE_COUNT + 1) : CFG_W;

	crr_state_t state_q, state_d;
	logic [CNT_W-1:0] clr_q;
	logic [SC_W-1:0] slot_q;
	logic [ST_W-1:0] stage_q, limit;
	logic out_valid_q;

	assign limit = (ST_W'(stages_in_use) > ST_W'(STAGE_COUNT)) ? ST_W'(STAGE_COUNT)
		: ST_W'(stages_in_use);
	assign clear_addr = clr_q[ADR_W-1:0];
	assign scan_addr = ADR_W'(32'(stage_q) * ENTRIES_PER_STAGE + 32'(slot_q));
	assign rd_valid_in = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			slot_q <= '0;
			stage_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (cmd.stage_init)
				slot_q <= '0;
			else if (cmd.scan_rd)
				slot_q <= slot_q + 1'b1;
			if (cmd.load_req)
				stage_q <= '0;
			else if (cmd.apply)
				stage_q <= stage_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_ent = 1'b1;
				if (32'(clr_q) == DEPTH - 1)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					cmd.stage_init = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!stat.is_translate) begin
					cmd.write_ent = stat.write_ok;
					state_d = ST_IDLE;
				end else if (stage_q >= limit) begin
					if (!out_valid_q || out_ready) begin
						cmd.out_load = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.scan_rd = 1'b1;
					cmd.scan_cmp = (slot_q != '0);
					if (32'(slot_q) == ENTRIES_PER_STAGE - 1)
						state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				cmd.scan_cmp = 1'b1;
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				cmd.stage_init = 1'b1;
				state_d = ST_SCAN;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/crr_checker.sv =====
// Port-level checker for chained_range_remap_min, bound to the top level.
// Depends on chained_range_remap_min_assert.svh.
`default_nettype none
`include "chained_range_remap_min_assert.svh"
module crr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic rsp_done,
	input wire logic [47:0] rsp_loc,
	input wire logic [47:0] rsp_min
);
	logic [96:0] rsp_bits;
	assign rsp_bits = {rsp_loc, rsp_min, rsp_done};

	// hold a stalled result
	`CRR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bits))
	// minimum never above the value it reports with
	`CRR_ASSERT_NOW(a_min_le, clk, arst_n, rsp_valid, rsp_min <= rsp_loc)
	// one request at a time
	`CRR_ASSERT_NEXT(a_one_req, clk, arst_n, req_valid && req_ready, !req_ready)
endmodule

bind chained_range_remap_min crr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_done(rsp.batch_done),
	.rsp_loc(rsp.location_value[47:0]), .rsp_min(rsp.batch_minimum[47:0])
);
`default_nettype wire
